@@ design/pcc_pkg.sv @@
// Package for the palette colour cycler: shared constants, register indexes
// and the control structs passed between the cycler's modules.
// No dependencies.
package pcc_pkg;

    // Palette depth default and the longest strip that can be cycled
    localparam int PALETTE_SIZE_DEF = 256;
    localparam int MAX_STRIP        = 64;

    // Time saturates at the largest 31-bit value
    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    // Register indexes on the configuration port (word address)
    localparam logic [2:0] REG_STRIP_FIRST  = 3'd0;
    localparam logic [2:0] REG_STRIP_LENGTH = 3'd1;
    localparam logic [2:0] REG_STEP_DELAY   = 3'd2;
    localparam logic [2:0] REG_REVERSE_DIR  = 3'd3;
    localparam logic [2:0] REG_SMOOTH_BLEND = 3'd4;

    // Input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration seen by the timing unit
    typedef struct packed {
        logic [6:0]  len;      // effective strip length, 1..MAX_STRIP
        logic [15:0] delay;
        logic        smooth;
    } t_tmr_cfg;

    // Outcome of one tick's timing calculation
    typedef struct packed {
        logic       done;      // one-cycle pulse
        logic       emit;      // this tick produces a run of entries
        logic [5:0] steps;     // rotation position, already below the length
        logic [7:0] f1;        // blend weight of the neighbouring entry
    } t_tick_res;

    // Side information travelling with a palette read
    typedef struct packed {
        logic       valid;
        logic [7:0] oidx;
        logic       last;
    } t_s1_meta;

endpackage

@@ design/pcc_if.sv @@
// Handshake channels of the palette colour cycler: tick/load input and
// palette update output. Depends on nothing.
interface pcc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [30:0] now_tick;

    modport source (output valid, op, entry_index, entry_color, now_tick, input ready);
    modport sink   (input valid, op, entry_index, entry_color, now_tick, output ready);
endinterface

interface pcc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_index;
    logic [31:0] out_color;
    logic        rgb_only;
    logic        last;

    modport source (output valid, out_index, out_color, rgb_only, last, input ready);
    modport sink   (input valid, out_index, out_color, rgb_only, last, output ready);
endinterface

@@ design/pcc_mem.sv @@
// Source palette store: one write port, two registered read ports.
// Depends on nothing; written only while the cycler is idle.
module pcc_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [31:0]   o_rdata0,
    output logic [31:0]   o_rdata1
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata0;
    logic [31:0] r_rdata1;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, held while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

@@ design/pcc_timer.sv @@
// Tick timing unit: holds rotation position, deadline and step start, and
// works out the rotation and blend weight of a tick. Depends on pcc_pkg.
module pcc_timer import pcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_now,
    input  t_tmr_cfg    i_cfg,
    output t_tick_res   o_res
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_MOD  = 2'd1;
    localparam logic [1:0] T_PREP = 2'd2;
    localparam logic [1:0] T_DIV  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [30:0] r_deadline, n_deadline;
    logic [30:0] r_start, n_start;
    logic [30:0] r_now, n_now;
    logic [2:0]  r_cnt, n_cnt;
    logic [6:0]  r_rem, n_rem;
    logic        r_stepped, n_stepped;
    logic [5:0]  r_steps, n_steps;
    logic [23:0] r_num, n_num;
    logic [15:0] r_span, n_span;
    logic [7:0]  r_q, n_q;
    logic        r_emit, n_emit;
    logic        r_done, n_done;

    always_comb begin
        logic [6:0]  rem_sh;
        logic [6:0]  rem_nx;
        logic [6:0]  pos_inc;
        logic [31:0] dl_sum;
        logic [30:0] span_w;
        logic [30:0] diff_w;
        logic [23:0] dvs;

        n_state    = r_state;
        n_pos      = r_pos;
        n_deadline = r_deadline;
        n_start    = r_start;
        n_now      = r_now;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_stepped  = r_stepped;
        n_steps    = r_steps;
        n_num      = r_num;
        n_span     = r_span;
        n_q        = r_q;
        n_emit     = r_emit;
        n_done     = 1'b0;

        rem_sh  = {r_rem[5:0], r_pos[r_cnt]};
        rem_nx  = (rem_sh >= i_cfg.len) ? rem_sh - i_cfg.len : rem_sh;
        pos_inc = {1'b0, rem_nx[5:0]} + 7'd1;
        dl_sum  = {1'b0, r_now} + {16'd0, i_cfg.delay};
        span_w  = r_deadline - r_start;
        diff_w  = r_now - r_start;
        dvs     = {8'd0, r_span} << r_cnt;

        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    n_now     = i_now;
                    n_stepped = (i_now >= r_deadline);
                    n_rem     = 7'd0;
                    n_cnt     = 3'd5;
                    n_q       = 8'd0;
                    n_state   = T_MOD;
                end
            end
            // Position modulo length, one bit per cycle
            T_MOD: begin
                n_rem = rem_nx;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_emit = i_cfg.smooth | r_stepped;
                    if (r_stepped) begin
                        n_pos      = (pos_inc == i_cfg.len) ? 6'd0 : pos_inc[5:0];
                        n_steps    = (pos_inc == i_cfg.len) ? 6'd0 : pos_inc[5:0];
                        n_deadline = dl_sum[31] ? TIME_MAX : dl_sum[30:0];
                        n_start    = r_now;
                    end else begin
                        n_steps = rem_nx[5:0];
                    end
                    if (i_cfg.smooth) begin
                        n_state = T_PREP;
                    end else begin
                        n_done  = 1'b1;
                        n_state = T_IDLE;
                    end
                end
            end
            // Blend weight set-up; the span never exceeds the 16-bit delay
            T_PREP: begin
                if (span_w == 31'd0 || r_now < r_start) begin
                    n_q     = 8'd0;
                    n_done  = 1'b1;
                    n_state = T_IDLE;
                end else if (diff_w >= span_w) begin
                    n_q     = 8'hFF;
                    n_done  = 1'b1;
                    n_state = T_IDLE;
                end else begin
                    n_num   = {diff_w[15:0], 8'd0} - {8'd0, diff_w[15:0]};
                    n_span  = span_w[15:0];
                    n_cnt   = 3'd7;
                    n_q     = 8'd0;
                    n_state = T_DIV;
                end
            end
            // Restoring division, one quotient bit per cycle
            T_DIV: begin
                if (r_num >= dvs) begin
                    n_num      = r_num - dvs;
                    n_q[r_cnt] = 1'b1;
                end
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_done  = 1'b1;
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_IDLE;
            r_pos      <= 6'd0;
            r_deadline <= 31'd0;
            r_start    <= 31'd0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_deadline <= n_deadline;
            r_start    <= n_start;
            r_done     <= n_done;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_stepped <= n_stepped;
        r_steps   <= n_steps;
        r_num     <= n_num;
        r_span    <= n_span;
        r_q       <= n_q;
        r_emit    <= n_emit;
    end

    assign o_res.done  = r_done;
    assign o_res.emit  = r_emit;
    assign o_res.steps = r_steps;
    assign o_res.f1    = r_q;

endmodule

@@ design/pcc_mix.sv @@
// Colour mixing pipeline: weight products, divide by 255 and output register.
// Depends on pcc_pkg.
module pcc_mix import pcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_smooth,
    input  logic [7:0]  i_f1,
    input  t_s1_meta    i_meta,
    input  logic [31:0] i_col_a,
    input  logic [31:0] i_col_b,
    output logic        o_busy,
    output logic        o_valid,
    output logic [7:0]  o_index,
    output logic [31:0] o_color,
    output logic        o_rgb_only,
    output logic        o_last
);

    logic        r_v2;
    logic [7:0]  r_oidx2;
    logic        r_last2;
    logic [31:0] r_col2;
    logic [15:0] r_pa [3];
    logic [15:0] r_pb [3];

    logic        r_v3;
    logic [7:0]  r_oidx3;
    logic        r_last3;
    logic [31:0] r_col3;
    logic        r_rgb3;

    logic [7:0]  f0;
    logic [23:0] mixed;

    assign f0 = 8'hFF - i_f1;

    // Exact x/255 for any product of two 8-bit values
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mixed[8*k +: 8] = div255(r_pa[k]) + div255(r_pb[k]);
        end
    end

    // Stage 2: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oidx2 <= i_meta.oidx;
            r_last2 <= i_meta.last;
            r_col2  <= i_col_a;
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= i_col_a[8*k +: 8] * f0;
                r_pb[k] <= i_col_b[8*k +: 8] * i_f1;
            end
        end
    end

    // Stage 3: output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oidx3 <= r_oidx2;
            r_last3 <= r_last2;
            r_rgb3  <= i_smooth;
            r_col3  <= i_smooth ? {8'd0, mixed} : r_col2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_meta.valid;
            r_v3 <= r_v2;
        end
    end

    assign o_busy     = r_v2 | r_v3;
    assign o_valid    = r_v3;
    assign o_index    = r_oidx3;
    assign o_color    = r_col3;
    assign o_rgb_only = r_rgb3;
    assign o_last     = r_last3;

endmodule

@@ design/palette_color_cycler_core.sv @@
// Top level of the palette colour cycler: configuration registers, tick
// sequencer and strip walk. Depends on pcc_pkg, pcc_if, pcc_mem, pcc_timer
// and pcc_mix.
//
//  channel  direction  transaction                       handshake
//  i_in     in         load colour or time tick           valid/ready
//  o_out    out        one destination palette update     valid/ready
//  apb      in/out     register write/read                psel/penable, pready=1
//
// A load is written to the palette as it is accepted. A tick works out the
// position modulo length one bit at a time, and blend mode then adds a
// set-up step and the weight division. A tick that steps, or any tick in
// blend mode, then reads the strip at one entry per cycle while the output
// does not stall (dual-port palette read) and drains a 3-stage pipeline
// before the next transaction is taken.
// Output stalls freeze the whole walk. Reset is synchronous; no clearing pass.
module palette_color_cycler_core import pcc_pkg::*; #(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcc_in_if.sink      i_in,
    pcc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(PALETTE_SIZE);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    // Configuration registers
    logic [7:0]  r_strip_first;
    logic [6:0]  r_strip_length;
    logic [15:0] r_step_delay;
    logic        r_reverse_dir;
    logic        r_smooth_blend;

    logic [1:0]  r_state, n_state;
    logic [6:0]  r_c, n_c;
    logic [5:0]  r_i0, n_i0;
    logic [5:0]  r_i1, n_i1;
    logic [7:0]  r_f1, n_f1;
    logic        r_smooth, n_smooth;
    t_s1_meta    r_meta1, n_meta1;

    logic        cfg_wr;
    logic [6:0]  len_eff;
    t_tmr_cfg    tmr_cfg;
    t_tick_res   tick_res;
    logic        in_acc;
    logic        en;
    logic        mix_busy;
    logic [31:0] col_a;
    logic [31:0] col_b;

    logic [PW-1:0] mod_tab [256];
    logic [PW-1:0] base;
    logic [PW-1:0] addr0;
    logic [PW-1:0] addr1;
    logic [PW-1:0] oaddr;
    logic [PW-1:0] load_addr;

    // Index reduction table, worked out at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_tab[g] = PW'(g % PALETTE_SIZE);
    end

    // Sum of two reduced indexes, brought back below the palette size
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW+1)'(PALETTE_SIZE)) begin
            s = s - (PW+1)'(PALETTE_SIZE);
        end
        return s[PW-1:0];
    endfunction

    // Next strip offset with wrap at the length
    function automatic logic [5:0] inc_wrap(input logic [5:0] v, input logic [6:0] n);
        logic [6:0] t;
        t = {1'b0, v} + 7'd1;
        return (t == n) ? 6'd0 : t[5:0];
    endfunction

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_first  <= 8'd0;
            r_strip_length <= 7'd1;
            r_step_delay   <= 16'd0;
            r_reverse_dir  <= 1'b0;
            r_smooth_blend <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_STRIP_FIRST:  r_strip_first  <= pwdata[7:0];
                REG_STRIP_LENGTH: r_strip_length <= pwdata[6:0];
                REG_STEP_DELAY:   r_step_delay   <= pwdata[15:0];
                REG_REVERSE_DIR:  r_reverse_dir  <= pwdata[0];
                REG_SMOOTH_BLEND: r_smooth_blend <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_STRIP_FIRST:  prdata = {24'd0, r_strip_first};
            REG_STRIP_LENGTH: prdata = {25'd0, r_strip_length};
            REG_STEP_DELAY:   prdata = {16'd0, r_step_delay};
            REG_REVERSE_DIR:  prdata = {31'd0, r_reverse_dir};
            REG_SMOOTH_BLEND: prdata = {31'd0, r_smooth_blend};
            default:          prdata = 32'd0;
        endcase
    end

    // Effective strip length
    always_comb begin
        if (r_strip_length == 7'd0) begin
            len_eff = 7'd1;
        end else if (r_strip_length > 7'(MAX_STRIP)) begin
            len_eff = 7'(MAX_STRIP);
        end else begin
            len_eff = r_strip_length;
        end
    end

    assign tmr_cfg.len    = len_eff;
    assign tmr_cfg.delay  = r_step_delay;
    assign tmr_cfg.smooth = r_smooth_blend;

    // Input handshake: one transaction at a time
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid & (r_state == S_IDLE);

    // Whole read/mix pipeline advances when the output register can move
    assign en = ~o_out.valid | o_out.ready;

    // Palette addresses
    assign base      = mod_tab[r_strip_first];
    assign addr0     = wrap_add(base, mod_tab[{2'b00, r_i0}]);
    assign addr1     = wrap_add(base, mod_tab[{2'b00, r_i1}]);
    assign oaddr     = wrap_add(base, mod_tab[{1'b0, r_c}]);
    assign load_addr = mod_tab[i_in.entry_index];

    // Tick sequencer and strip walk
    always_comb begin
        logic [5:0] rv0;

        n_state  = r_state;
        n_c      = r_c;
        n_i0     = r_i0;
        n_i1     = r_i1;
        n_f1     = r_f1;
        n_smooth = r_smooth;
        n_meta1  = r_meta1;

        rv0 = (tick_res.steps == 6'd0) ? 6'd0 : 6'(len_eff - {1'b0, tick_res.steps});

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.op == OP_TICK) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (tick_res.done) begin
                    n_c      = 7'd0;
                    n_f1     = tick_res.f1;
                    n_smooth = r_smooth_blend;
                    if (r_reverse_dir) begin
                        n_i0 = rv0;
                        n_i1 = (rv0 == 6'd0) ? 6'(len_eff - 7'd1) : rv0 - 6'd1;
                    end else begin
                        n_i0 = tick_res.steps;
                        n_i1 = inc_wrap(tick_res.steps, len_eff);
                    end
                    n_state = tick_res.emit ? S_RUN : S_IDLE;
                end
            end
            S_RUN: begin
                if (en) begin
                    n_c  = r_c + 7'd1;
                    n_i0 = inc_wrap(r_i0, len_eff);
                    n_i1 = inc_wrap(r_i1, len_eff);
                    if (r_c + 7'd1 == len_eff) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!r_meta1.valid && !mix_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Side information for the entry being read this cycle
        if (en) begin
            n_meta1.valid = (r_state == S_RUN);
            n_meta1.oidx  = 8'(oaddr);
            n_meta1.last  = (r_c + 7'd1 == len_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_meta1.valid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_meta1.valid <= n_meta1.valid;
        end
        r_meta1.oidx <= n_meta1.oidx;
        r_meta1.last <= n_meta1.last;
    end

    always_ff @(posedge i_clk) begin
        r_c          <= n_c;
        r_i0         <= n_i0;
        r_i1         <= n_i1;
        r_f1         <= n_f1;
        r_smooth     <= n_smooth;
    end

    // Loads write only while idle, so reads of a run never meet a write
    pcc_mem #(
        .DEPTH (PALETTE_SIZE),
        .AW    (PW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (in_acc && i_in.op == OP_LOAD),
        .i_waddr  (load_addr),
        .i_wdata  (i_in.entry_color),
        .i_re     (en),
        .i_raddr0 (addr0),
        .i_raddr1 (addr1),
        .o_rdata0 (col_a),
        .o_rdata1 (col_b)
    );

    pcc_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && i_in.op == OP_TICK),
        .i_now   (i_in.now_tick),
        .i_cfg   (tmr_cfg),
        .o_res   (tick_res)
    );

    pcc_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_smooth   (r_smooth),
        .i_f1       (r_f1),
        .i_meta     (r_meta1),
        .i_col_a    (col_a),
        .i_col_b    (col_b),
        .o_busy     (mix_busy),
        .o_valid    (o_out.valid),
        .o_index    (o_out.out_index),
        .o_color    (o_out.out_color),
        .o_rgb_only (o_out.rgb_only),
        .o_last     (o_out.last)
    );

endmodule
